### design/ccdr_pkg.sv
// ----------------------------------------------------------------------------
// ccdr_pkg - shared types and constants for the cursor clamp unit
// Fixed-point widths, register indexes, outcome codes, the rectangle layout
// and the token that travels down the cell chain.
// ----------------------------------------------------------------------------
package ccdr_pkg;

	localparam int DEF_MAX_DISPLAYS = 7;
	localparam int FRACTION_BITS    = 8;

	localparam int POS_W   = 24;                    // cursor coordinate
	localparam int EDGE_W  = 16 + 2 + FRACTION_BITS; // scaled rect edge, signed
	localparam int DIFF_W  = EDGE_W + 1;            // point minus edge
	localparam int MAG_W   = EDGE_W;                // |difference|
	localparam int SQ_W    = 2 * MAG_W;
	localparam int DIST_W  = SQ_W + 1;              // dx^2 + dy^2
	localparam int CNT_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_RECT_0 = 3'd1;

	// outcome codes
	localparam logic [1:0] OC_INSIDE  = 2'd0;
	localparam logic [1:0] OC_CLAMPED = 2'd1;
	localparam logic [1:0] OC_ORIGIN  = 2'd2;
	localparam logic [1:0] OC_SET     = 2'd3;

	typedef struct packed {
		logic [15:0]        height;
		logic [15:0]        width;
		logic signed [15:0] oy;
		logic signed [15:0] ox;
	} ccdr_rect_t;

	typedef struct packed {
		logic                     set;
		logic                     in_rect;
		logic                     clamped;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic [DIST_W-1:0]        best;
		logic signed [EDGE_W-1:0] bx;
		logic signed [EDGE_W-1:0] by;
	} ccdr_tok_t;

	// saturate a wide signed value into the cursor range
	function automatic logic [POS_W-1:0] sat_pos(input logic [EDGE_W-1:0] v);
		logic [EDGE_W-POS_W:0] top;
		top = v[EDGE_W-1:POS_W-1];
		if (top == '0 || top == '1)
			return v[POS_W-1:0];
		else if (v[EDGE_W-1])
			return {1'b1, {(POS_W-1){1'b0}}};
		else
			return {1'b0, {(POS_W-1){1'b1}}};
	endfunction

endpackage

### design/ccdr_cell.sv
// ----------------------------------------------------------------------------
// ccdr_cell - one link of the rectangle chain
// Stage 1 clamps the point to the rectangle and squares the offsets; stage 2
// sums them and keeps the nearer candidate. The seed cell loads the distance
// to the origin as the starting best.
// ----------------------------------------------------------------------------
module ccdr_cell import ccdr_pkg::*; #(
	parameter bit SEED = 1'b0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_in,
	input  ccdr_tok_t  tok_in,
	input  ccdr_rect_t rect,
	input  logic       active,
	output logic       valid_out,
	output ccdr_tok_t  tok_out
);

	logic signed [EDGE_W-1:0] x0, x1, y0, y1, pxe, pye, cx, cy;
	logic signed [DIFF_W-1:0] dx, dy, ax, ay;
	logic [MAG_W-1:0]         magx, magy;
	logic                     hit;

	always_comb begin
		x0  = EDGE_W'($signed(rect.ox)) <<< FRACTION_BITS;
		y0  = EDGE_W'($signed(rect.oy)) <<< FRACTION_BITS;
		x1  = (EDGE_W'($signed(rect.ox)) + $signed(EDGE_W'(rect.width))) <<< FRACTION_BITS;
		y1  = (EDGE_W'($signed(rect.oy)) + $signed(EDGE_W'(rect.height))) <<< FRACTION_BITS;
		pxe = EDGE_W'($signed(tok_in.px));
		pye = EDGE_W'($signed(tok_in.py));
		hit = (pxe >= x0) && (pxe < x1) && (pye >= y0) && (pye < y1);
		// far edge if beyond it, the point if past the origin, else the origin
		cx  = (x1 < pxe) ? x1 : ((pxe > x0) ? pxe : x0);
		cy  = (y1 < pye) ? y1 : ((pye > y0) ? pye : y0);
		dx  = DIFF_W'(pxe) - DIFF_W'(cx);
		dy  = DIFF_W'(pye) - DIFF_W'(cy);
		ax  = dx[DIFF_W-1] ? -dx : dx;
		ay  = dy[DIFF_W-1] ? -dy : dy;
		magx = ax[MAG_W-1:0];
		magy = ay[MAG_W-1:0];
	end

	logic                     v_s1, v_s2;
	ccdr_tok_t                tok_s1, tok_s2, tok_nx;
	logic signed [EDGE_W-1:0] cx_s1, cy_s1;
	logic [SQ_W-1:0]          sqx_s1, sqy_s1;
	logic                     hit_s1, use_s1;
	logic [DIST_W-1:0]        dsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in) begin
			tok_s1 <= tok_in;
			cx_s1  <= cx;
			cy_s1  <= cy;
			sqx_s1 <= magx * magx;
			sqy_s1 <= magy * magy;
			hit_s1 <= hit;
			use_s1 <= active && !tok_in.in_rect && !tok_in.set;
		end
	end

	always_comb begin
		dsum   = DIST_W'(sqx_s1) + DIST_W'(sqy_s1);
		tok_nx = tok_s1;
		if (SEED) begin
			tok_nx.best = dsum;
			tok_nx.bx   = cx_s1;
			tok_nx.by   = cy_s1;
		end else if (use_s1) begin
			if (hit_s1) begin
				tok_nx.in_rect = 1'b1;
			end else if (dsum < tok_s1.best) begin
				// strict: earlier rectangle or origin keeps a tie
				tok_nx.best    = dsum;
				tok_nx.bx      = cx_s1;
				tok_nx.by      = cy_s1;
				tok_nx.clamped = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1)
			tok_s2 <= tok_nx;
	end

	assign valid_out = v_s2;
	assign tok_out   = tok_s2;

endmodule

### design/cursor_clamp_to_display_rects_unit.sv
// ----------------------------------------------------------------------------
// cursor_clamp_to_display_rects_unit - cursor keeper with display clamping
// Holds the Q16.8 cursor, applies move and set items, and pulls a moved
// cursor back onto the nearest active display rectangle.
// ----------------------------------------------------------------------------
// One item is processed at a time. A move item is added to the cursor with
// saturation, then runs down a chain of cells: an origin cell that seeds the
// best distance with the distance to (0,0), followed by one cell per display
// rectangle, each with a clamp-and-square stage and a sum-and-compare stage.
// req_ready returns when the result moves from the tail register into the
// output register, so a new item is not taken before the last is through.
// Set items go down the same chain with their position left untouched.
// The output register lets the next item be accepted while a result waits.
// Configuration writes take effect at once and must only be made while idle.
// ----------------------------------------------------------------------------
module cursor_clamp_to_display_rects_unit import ccdr_pkg::*; #(
	parameter int MAX_DISPLAYS = DEF_MAX_DISPLAYS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// request items
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic                    req_type,
	input  logic signed [POS_W-1:0] move_x,
	input  logic signed [POS_W-1:0] move_y,
	// result items
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic [1:0]              outcome
);

	// ---- configuration registers ------------------------------------------
	logic [CNT_W-1:0] count_q;
	ccdr_rect_t       rect_q [MAX_DISPLAYS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int k = 0; k < MAX_DISPLAYS; k++)
				rect_q[k] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_DISPLAY_COUNT)
				count_q <= cfg_data[CNT_W-1:0];
			// indexes past the stored rectangles are dropped
			for (int k = 0; k < MAX_DISPLAYS; k++)
				if (cfg_index == CFG_IDX_W'(32'(CFG_DISPLAY_RECT_0) + k))
					rect_q[k] <= cfg_data;
		end
	end

	// a count above the number of cells acts as all cells
	logic [CNT_W-1:0]        n_eff;
	logic [MAX_DISPLAYS-1:0] active;

	always_comb begin
		n_eff = (count_q > CNT_W'(MAX_DISPLAYS)) ? CNT_W'(MAX_DISPLAYS) : count_q;
		for (int k = 0; k < MAX_DISPLAYS; k++)
			active[k] = CNT_W'(k) < n_eff;
	end

	// ---- front stage: saturating add or direct load ----------------------
	logic                    busy_q;
	logic                    req_acc;
	logic signed [POS_W-1:0] cursor_x_q, cursor_y_q;
	logic [EDGE_W-1:0]       sum_x, sum_y;
	logic                    v_s0;
	ccdr_tok_t               tok_s0;

	assign req_ready = !busy_q;
	assign req_acc   = req_valid && req_ready;

	always_comb begin
		sum_x = EDGE_W'($signed(cursor_x_q)) + EDGE_W'($signed(move_x));
		sum_y = EDGE_W'($signed(cursor_y_q)) + EDGE_W'($signed(move_y));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s0 <= 1'b0;
		else
			v_s0 <= req_acc;
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			tok_s0.set     <= req_type;
			tok_s0.in_rect <= 1'b0;
			tok_s0.clamped <= 1'b0;
			tok_s0.px      <= req_type ? move_x : sat_pos(sum_x);
			tok_s0.py      <= req_type ? move_y : sat_pos(sum_y);
			tok_s0.best    <= '0;
			tok_s0.bx      <= '0;
			tok_s0.by      <= '0;
		end
	end

	// ---- cell chain: origin seed, then one cell per rectangle ------------
	ccdr_tok_t               tok_c [MAX_DISPLAYS+2];
	logic [MAX_DISPLAYS+1:0] v_c;

	assign tok_c[0] = tok_s0;
	assign v_c[0]   = v_s0;

	for (genvar k = 0; k <= MAX_DISPLAYS; k++) begin : g_chain
		if (k == 0) begin : g_seed
			ccdr_cell #(.SEED(1'b1)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.valid_in  (v_c[k]),
				.tok_in    (tok_c[k]),
				.rect      ('0),
				.active    (1'b1),
				.valid_out (v_c[k+1]),
				.tok_out   (tok_c[k+1])
			);
		end else begin : g_disp
			ccdr_cell #(.SEED(1'b0)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.valid_in  (v_c[k]),
				.tok_in    (tok_c[k]),
				.rect      (rect_q[k-1]),
				.active    (active[k-1]),
				.valid_out (v_c[k+1]),
				.tok_out   (tok_c[k+1])
			);
		end
	end

	// ---- tail: pick the result and update the cursor ---------------------
	logic                    last_v;
	ccdr_tok_t               last_tok;
	logic signed [POS_W-1:0] res_x, res_y;
	logic [1:0]              res_oc;

	assign last_v   = v_c[MAX_DISPLAYS+1];
	assign last_tok = tok_c[MAX_DISPLAYS+1];

	always_comb begin
		if (last_tok.set) begin
			res_x  = last_tok.px;
			res_y  = last_tok.py;
			res_oc = OC_SET;
		end else if (last_tok.in_rect) begin
			res_x  = last_tok.px;
			res_y  = last_tok.py;
			res_oc = OC_INSIDE;
		end else begin
			// clamped edge can sit beyond the cursor range
			res_x  = sat_pos(last_tok.bx);
			res_y  = sat_pos(last_tok.by);
			res_oc = last_tok.clamped ? OC_CLAMPED : OC_ORIGIN;
		end
	end

	logic                    tail_v_q;
	logic signed [POS_W-1:0] tail_x_q, tail_y_q;
	logic [1:0]              tail_oc_q;
	logic                    rsp_valid_q;
	logic                    tail_move;

	assign tail_move = tail_v_q && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_v_q    <= 1'b0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
		end else begin
			if (last_v) begin
				tail_v_q   <= 1'b1;
				cursor_x_q <= res_x;
				cursor_y_q <= res_y;
			end else if (tail_move) begin
				tail_v_q <= 1'b0;
			end
			// busy from acceptance until the item leaves the tail
			if (req_acc)
				busy_q <= 1'b1;
			else if (tail_move)
				busy_q <= 1'b0;
			if (tail_move)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_v) begin
			tail_x_q  <= res_x;
			tail_y_q  <= res_y;
			tail_oc_q <= res_oc;
		end
	end

	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic [1:0]              outcome_q;

	always_ff @(posedge clk) begin
		if (tail_move) begin
			pos_x_q   <= tail_x_q;
			pos_y_q   <= tail_y_q;
			outcome_q <= tail_oc_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign outcome   = outcome_q;

`ifndef NO_ASSERTIONS
	// only one item is ever in flight along the chain and tail
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tail_v_q, v_c}))
		else $error("more than one item in the chain");

	// chain activity without a busy flag means a lost handshake
	a_busy_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(|v_c || tail_v_q) |-> busy_q)
		else $error("item in flight while not busy");

	// a fall-back result always lands on the origin
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && outcome == OC_ORIGIN) |-> (pos_x == '0 && pos_y == '0))
		else $error("origin outcome with non-zero position");

	// the tail holds a chain result in the cycle after it appears
	a_tail_load: assert property (@(posedge clk) disable iff (!arst_n)
		last_v |=> tail_v_q)
		else $error("tail missed a chain result");
`endif

endmodule
